// ===== rtl/kfc_pkg.sv =====
// package: sizes, operation and status codes, result type and helpers for the keyed fifo
package kfc_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OP_W  = 3;
  localparam int DW    = 64;
  localparam int ST_W  = 2;
  localparam int OCC_W = 5;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
  localparam logic [OP_W-1:0] OP_CANCEL = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] STAT_OK        = 2'd0;
  localparam logic [ST_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [DW-1:0]    value;
    logic [OCC_W-1:0] occupancy;
  } res_t;

  // ring slot of a logical position, both below DEPTH
  function automatic logic [AW-1:0] kfc_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] pos);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // entry count masked to the occupancy width
  function automatic logic [OCC_W-1:0] kfc_occ(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+OCC_W-1:0] e;
    e = (CNT_W+OCC_W)'(cnt);
    return e[OCC_W-1:0];
  endfunction

endpackage

// ===== rtl/kfc_ram.sv =====
// entry store: one write port, one read port with registered read data
module kfc_ram #(
  parameter int DEPTH_P = 16,
  parameter int DATA_W  = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                            wdata,
  input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                            rdata
);

  logic [DATA_W-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kfc_seq.sv =====
// sequencer: ring pointers, search compare and gap-closing shift over the entry store
module kfc_seq
  import kfc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OP_W-1:0] in_op,
  input  logic [DW-1:0]   in_key,
  input  logic [DW-1:0]   in_new_value,
  output logic            res_valid,
  input  logic            res_ready,
  output res_t            res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [DW-1:0]    key_r, key_nxt;
  logic [DW-1:0]    nv_r, nv_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    pidx_r, pidx_nxt;
  logic [AW-1:0]    widx_r, widx_nxt;
  logic [ST_W-1:0]  status_r, status_nxt;
  logic [DW-1:0]    value_r, value_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [DW-1:0]    wdata;
  logic [AW-1:0]    raddr;
  logic [DW-1:0]    rdata;
  logic             hit;
  logic             in_fire;

  kfc_ram #(.DEPTH_P(DEPTH), .DATA_W(DW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign hit       = (rdata == key_r);
  assign res_valid = (state_r == S_DONE);
  assign res.status    = status_r;
  assign res.value     = value_r;
  assign res.occupancy = kfc_occ(count_r);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    nv_nxt     = nv_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    pidx_nxt   = pidx_r;
    widx_nxt   = widx_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    we         = 1'b0;
    waddr      = kfc_phys(head_r, widx_r);
    wdata      = rdata;
    raddr      = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          key_nxt    = in_key;
          nv_nxt     = in_new_value;
          status_nxt = STAT_OK;
          value_nxt  = '0;
          state_nxt  = S_DONE;
          unique case (in_op) inside
            OP_PUSH: begin
              if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = STAT_FULL;
              end else begin
                we        = 1'b1;
                waddr     = kfc_phys(head_r, AW'(count_r));
                wdata     = in_key;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                raddr     = head_r;
                state_nxt = S_POP;
              end
            end
            OP_UPDATE, OP_CANCEL: begin
              if (count_r == '0) begin
                status_nxt = STAT_NOT_FOUND;
              end else begin
                raddr     = kfc_phys(head_r, AW'(count_r - CNT_W'(1)));
                pidx_nxt  = AW'(count_r - CNT_W'(1));
                state_nxt = S_SRCH;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              head_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        value_nxt = rdata;
        head_nxt  = kfc_phys(head_r, AW'(1));
        count_nxt = count_r - CNT_W'(1);
        state_nxt = S_DONE;
      end
      S_SRCH: begin
        if (hit) begin
          if (op_r == OP_UPDATE) begin
            we        = 1'b1;
            waddr     = kfc_phys(head_r, pidx_r);
            wdata     = nv_r;
            state_nxt = S_DONE;
          end else begin
            value_nxt = rdata;
            if (CNT_W'(pidx_r) + CNT_W'(1) == count_r) begin
              count_nxt = count_r - CNT_W'(1);
              state_nxt = S_DONE;
            end else begin
              raddr     = kfc_phys(head_r, pidx_r + AW'(1));
              widx_nxt  = pidx_r;
              state_nxt = S_SHIFT;
            end
          end
        end else if (pidx_r == '0) begin
          status_nxt = STAT_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          raddr    = kfc_phys(head_r, pidx_r - AW'(1));
          pidx_nxt = pidx_r - AW'(1);
        end
      end
      S_SHIFT: begin
        // move the entry behind the gap one slot toward the head
        we    = 1'b1;
        waddr = kfc_phys(head_r, widx_r);
        wdata = rdata;
        if (CNT_W'(widx_r) + CNT_W'(2) == count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          raddr    = kfc_phys(head_r, AW'(CNT_W'(widx_r) + CNT_W'(2)));
          widx_nxt = widx_r + AW'(1);
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    nv_r     <= nv_nxt;
    pidx_r   <= pidx_nxt;
    widx_r   <= widx_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < (AW+1)'(DEPTH))
    else $error("head pointer outside store");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("accepted item did not start work");

  a_shift_inside: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> CNT_W'(widx_r) + CNT_W'(2) <= count_r)
    else $error("shift beyond last entry");

  a_search_inside: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH |-> CNT_W'(pidx_r) < count_r)
    else $error("search beyond last entry");

endmodule

// ===== rtl/keyed_fifo_with_cancel.sv =====
// keyed fifo with cancel: top level with sequencer and output register
//
//  channel  | valid     | stall      | payload
//  ---------+-----------+------------+-------------------------------------
//  input    | in_valid  | in_stall   | in_op, in_key, in_new_value
//  result   | out_valid | out_stall  | out_status, out_value, out_occupancy
//
//  push, clear and unused codes finish straight from idle, pop first reads the head entry
//  update compares entries from the newest back until a hit or past the oldest entry
//  cancel compares the same way, then moves the entries behind the hit to close the gap
//  work is serialised by the single read port of the entry store
//  reset is synchronous on rst_n and empties the queue at once
//  a finished result waits in the output register while the next item is taken
module keyed_fifo_with_cancel
  import kfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  in_op,
  input  logic [DW-1:0]    in_key,
  input  logic [DW-1:0]    in_new_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ST_W-1:0]  out_status,
  output logic [DW-1:0]    out_value,
  output logic [OCC_W-1:0] out_occupancy
);

  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid_r, out_valid_nxt;
  res_t out_r, out_nxt;

  kfc_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_key       (in_key),
    .in_new_value (in_new_value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_value     = out_r.value;
  assign out_occupancy = out_r.occupancy;

endmodule

// ===== test/keyed_fifo_with_cancel_tb.sv =====
// testbench for keyed_fifo_with_cancel: queue shadow, random ops, stall pressure
`timescale 1ns / 1ps

module keyed_fifo_with_cancel_tb
  import kfc_pkg::*;
();

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 345;
  localparam int MODE_SPAN   = 48;
  localparam int DRAIN_WAIT  = 4 * DEPTH;

  class keyed_queue_shadow;
    logic [DW-1:0] entries[$];
    res_t          awaited[$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [DW-1:0] key,
                               logic [DW-1:0] new_value);
      res_t r;
      int   hit;
      r.status    = STAT_OK;
      r.value     = '0;
      r.occupancy = '0;
      hit         = -1;
      if (op == OP_UPDATE || op == OP_CANCEL) begin
        for (int i = entries.size() - 1; i >= 0 && hit < 0; i--) begin
          if (entries[i] == key) begin
            hit = i;
          end
        end
      end
      case (op)
        OP_PUSH: begin
          if (entries.size() >= DEPTH) r.status = STAT_FULL;
          else entries.push_back(key);
        end
        OP_POP: begin
          if (entries.size() == 0) r.status = STAT_EMPTY;
          else r.value = entries.pop_front();
        end
        OP_UPDATE: begin
          if (hit < 0) r.status = STAT_NOT_FOUND;
          else entries[hit] = new_value;
        end
        OP_CANCEL: begin
          if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            r.value = entries[hit];
            entries.delete(hit);
          end
        end
        OP_CLEAR: begin
          entries.delete();
        end
        default: begin
        end
      endcase
      r.occupancy = OCC_W'(entries.size());
      awaited.push_back(r);
    endfunction

    function void check_reply(logic [ST_W-1:0] status, logic [DW-1:0] value,
                              logic [OCC_W-1:0] occupancy);
      res_t e;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result: status %0d value %h occupancy %0d",
                       status, value, occupancy));
        return;
      end
      e = awaited.pop_front();
      if (e.status !== status || e.value !== value || e.occupancy !== occupancy) begin
        flag($sformatf("mismatch: expected status %0d value %h occupancy %0d, got %0d %h %0d",
                       e.status, e.value, e.occupancy, status, value, occupancy));
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [OP_W-1:0]  in_op = OP_PUSH;
  logic [DW-1:0]    in_key = '0;
  logic [DW-1:0]    in_new_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ST_W-1:0]  out_status;
  logic [DW-1:0]    out_value;
  logic [OCC_W-1:0] out_occupancy;

  keyed_queue_shadow shadow = new();
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  bit                hold_request = 1'b0;
  int                quiet_cycles = 0;
  logic [DW-1:0]     key_pool[8];

  keyed_fifo_with_cancel uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_key       (in_key),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_value    (out_value),
    .out_occupancy(out_occupancy)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        shadow.check_reply(out_status, out_value, out_occupancy);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [DW-1:0] key,
                           input logic [DW-1:0] new_value);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_key       <= key;
    in_new_value <= new_value;
    do @(posedge clk); while (in_stall);
    shadow.note_request(op, key, new_value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  function automatic logic [DW-1:0] any_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [DW-1:0] pick_key(int pool_pct);
    if ($urandom_range(99) < pool_pct) return key_pool[$urandom_range(7)];
    return any_word();
  endfunction

  // fill mode favors pushes so the queue reaches full, drain mode empties it
  task automatic run_random(input int count);
    int               done;
    int               push_pct;
    int               pick;
    logic [OP_W-1:0]  op;
    done = 0;
    while (done < count) begin
      push_pct = ((done / MODE_SPAN) % 2 == 0) ? 55 : 20;
      pick = $urandom_range(99);
      if ($urandom_range(99) < push_pct) op = OP_PUSH;
      else if (pick < 35) op = OP_POP;
      else if (pick < 62) op = OP_UPDATE;
      else if (pick < 92) op = OP_CANCEL;
      else if (pick < 94) op = OP_CLEAR;
      else op = OP_W'($urandom_range(2 ** OP_W - 1, int'(OP_CLEAR) + 1));
      send_item(op, pick_key(75), pick_key(50));
      if (op <= OP_CLEAR) done++;
    end
  endtask

  initial begin
    logic [DW-1:0] dup_key;
    logic [DW-1:0] repl_key;
    foreach (key_pool[i]) key_pool[i] = any_word();
    dup_key  = key_pool[0];
    repl_key = key_pool[1];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue cases and unused codes
    send_item(OP_POP, '0, '0);
    send_item(OP_CANCEL, '1, '0);
    for (int c = int'(OP_CLEAR) + 1; c < 2 ** OP_W; c++) begin
      send_item(OP_W'(c), any_word(), any_word());
    end
    // extreme words, duplicates, then fill to full and push once more
    send_item(OP_PUSH, '0, '0);
    send_item(OP_PUSH, '1, '0);
    send_item(OP_PUSH, dup_key, '0);
    send_item(OP_PUSH, dup_key, '0);
    repeat (DEPTH - 4) send_item(OP_PUSH, any_word(), '1);
    send_item(OP_PUSH, any_word(), '0);
    // newest duplicate is updated, the older one is cancelled
    send_item(OP_UPDATE, dup_key, repl_key);
    send_item(OP_CANCEL, dup_key, '0);
    send_item(OP_CANCEL, '1, '1);
    send_item(OP_UPDATE, ~repl_key, '1);
    send_item(OP_CLEAR, '1, '1);

    send_idle_pct = 34;
    recv_idle_pct = 88;
    run_random(PHASE_ITEMS);
    send_idle_pct = 88;
    recv_idle_pct = 34;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    run_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kfc_pkg.sv
rtl/kfc_ram.sv
rtl/kfc_seq.sv
rtl/keyed_fifo_with_cancel.sv
test/keyed_fifo_with_cancel_tb.sv
